FILE: design/hdsc_pkg.sv
// ----------------------------------------------------------------------------
// hdsc_pkg: shared types and constants of the heat diffusion stencil
// Field widths, register indexes, reset values and the result-stage load.
// ----------------------------------------------------------------------------
`default_nettype none

package hdsc_pkg;

	// Fixed field widths
	localparam int CELL_W    = 15;
	localparam int POS_W     = 10;
	localparam int GRID_W    = 11;
	localparam int COEFF_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	// Parameter defaults
	localparam int DEF_MAX_GRID  = 1024;
	localparam int DEF_FRAC_BITS = 8;

	// Grid size limits and clamp ceiling (integer part)
	localparam int GRID_MIN  = 3;
	localparam int CLAMP_INT = 127;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_COEFF = 1'b1;

	// Register reset values
	localparam logic [GRID_W-1:0]  GRID_RESET  = 11'd1024;
	localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd15729;

	// One finished item handed to the result stage: up to two beats
	typedef struct packed {
		logic [POS_W-1:0]  row_a;
		logic [POS_W-1:0]  row_b;
		logic [POS_W-1:0]  col;
		logic [CELL_W-1:0] val_a;
		logic [CELL_W-1:0] val_b;
		logic              has_a;
		logic              has_b;
	} res_load_t;

endpackage

`default_nettype wire

FILE: design/hdsc_in_if.sv
// ----------------------------------------------------------------------------
// hdsc_in_if: input cell channel
// Valid/ready channel carrying one old cell and its frame start mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdsc_in_if;
	import hdsc_pkg::*;

	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_in;
	logic              frame_start;

	modport source (output valid, output cell_in, output frame_start, input ready);
	modport sink   (input valid, input cell_in, input frame_start, output ready);
endinterface

`default_nettype wire

FILE: design/hdsc_out_if.sv
// ----------------------------------------------------------------------------
// hdsc_out_if: result channel
// Valid/ready channel carrying one updated cell with its position.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdsc_out_if;
	import hdsc_pkg::*;

	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  out_row;
	logic [POS_W-1:0]  out_col;
	logic [CELL_W-1:0] cell_out;
	logic              last_of_run;

	modport source (output valid, output out_row, output out_col, output cell_out,
		output last_of_run, input ready);
	modport sink   (input valid, input out_row, input out_col, input cell_out,
		input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: design/heat_diffusion_stencil_clamped_unit.sv
// An accepted cell passes stage 1 and the result register before its first result beat.
// One cell per cycle while results are taken; a last-row cell sends two beats and stalls input.
// The line store read port sets stage 1: reads are registered on accept.
// Reset clears the position counters, the west window cell, the pipeline valids and
// loads the register reset values; the line stores are not cleared.
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_clamped_unit: streaming five-point heat stencil
// Raster cells in, updated cells with row and column out, two line stores.
// ----------------------------------------------------------------------------
`default_nettype none

module heat_diffusion_stencil_clamped_unit #(
	parameter int MAX_GRID  = hdsc_pkg::DEF_MAX_GRID,
	parameter int FRAC_BITS = hdsc_pkg::DEF_FRAC_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [hdsc_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [hdsc_pkg::CFG_DAT_W-1:0] wr_data,
	hdsc_in_if.sink                            cells,
	hdsc_out_if.source                         results
);
	import hdsc_pkg::*;

	localparam int AW = $clog2(MAX_GRID);

	// Clamp a written grid size to GRID_MIN .. MAX_GRID
	function automatic logic [AW:0] eff_size(input logic [GRID_W-1:0] v);
		int g;
		g = int'(v);
		if (g < GRID_MIN) begin
			g = GRID_MIN;
		end
		if (g > MAX_GRID) begin
			g = MAX_GRID;
		end
		return (AW+1)'(g);
	endfunction

	localparam logic [AW:0] G_RESET = eff_size(GRID_RESET);

	// Configuration
	logic [AW:0]        g_q;
	logic [AW:0]        gm1_q;
	logic [COEFF_W-1:0] coeff_q;

	// Position counters and window
	logic [AW-1:0]     col_q;
	logic [AW-1:0]     row_q;
	logic [CELL_W-1:0] win_q;

	// Stage 0 (accept) logic
	logic          accept;
	logic [AW:0]   c_w;
	logic [AW:0]   r_w;
	logic [AW-1:0] c0;
	logic [AW-1:0] r0;
	logic [AW:0]   c0p1;
	logic [AW:0]   r0p1;
	logic          ez0;

	// Stage 1
	logic              valid_s1;
	logic [CELL_W-1:0] x_s1;
	logic [AW-1:0]     c_s1;
	logic [AW-1:0]     r_s1;
	logic              has_a_s1;
	logic              has_b_s1;
	logic              border_s1;
	logic              ez_s1;
	logic              hit_c_s1;
	logic              hit_e_s1;
	logic [CELL_W-1:0] fwd_mid_s1;
	logic [CELL_W-1:0] fwd_up_s1;
	logic              s1_adv;
	logic              s2_free;

	// Line store reads
	logic [CELL_W-1:0] mid_c_rd;
	logic [CELL_W-1:0] mid_e_rd;
	logic [CELL_W-1:0] up_rd;
	logic [CELL_W-1:0] centre;
	logic [CELL_W-1:0] north;
	logic [CELL_W-1:0] east;
	logic [CELL_W-1:0] interior;
	res_load_t         res;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q     <= G_RESET;
			gm1_q   <= G_RESET - (AW+1)'(1);
			coeff_q <= COEFF_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GRID_SIZE: begin
					g_q   <= eff_size(wr_data[GRID_W-1:0]);
					gm1_q <= eff_size(wr_data[GRID_W-1:0]) - (AW+1)'(1);
				end
				REG_DIFF_COEFF: begin
					coeff_q <= wr_data[COEFF_W-1:0];
				end
			endcase
		end
	end

	// Position of the incoming cell, with frame start and wrap
	always_comb begin
		c_w = {1'b0, cells.frame_start ? AW'(0) : col_q};
		r_w = {1'b0, cells.frame_start ? AW'(0) : row_q};
		if (c_w >= g_q) begin
			c_w = '0;
			r_w = r_w + (AW+1)'(1);
		end
		if (r_w >= g_q) begin
			r_w = '0;
		end
	end

	assign c0   = c_w[AW-1:0];
	assign r0   = r_w[AW-1:0];
	assign c0p1 = {1'b0, c0} + (AW+1)'(1);
	assign r0p1 = {1'b0, r0} + (AW+1)'(1);
	assign ez0  = c0p1 >= g_q;

	// Handshake: stage 1 moves on when the result register can take it
	assign s1_adv      = valid_s1 && s2_free;
	assign cells.ready = !valid_s1 || s1_adv;
	assign accept      = cells.valid && cells.ready;

	// Counters step on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (ez0) begin
				col_q <= '0;
				row_q <= (r0p1 >= g_q) ? '0 : r0p1[AW-1:0];
			end else begin
				col_q <= c0p1[AW-1:0];
				row_q <= r0;
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cells.ready) begin
			valid_s1 <= cells.valid;
		end
	end

	// Stage 1 payload; forward the store write that coincides with the read
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1       <= cells.cell_in;
			c_s1       <= c0;
			r_s1       <= r0;
			has_a_s1   <= r0 != '0;
			has_b_s1   <= {1'b0, r0} == gm1_q;
			border_s1  <= r0 == AW'(1) || c0 == '0 || {1'b0, c0} == gm1_q;
			ez_s1      <= ez0;
			hit_c_s1   <= s1_adv && c_s1 == c0;
			hit_e_s1   <= s1_adv && c_s1 == c0p1[AW-1:0];
			fwd_mid_s1 <= x_s1;
			fwd_up_s1  <= centre;
		end
	end

	// Line stores: middle is kept twice for the centre and east reads
	hdsc_ram #(.WIDTH(CELL_W), .DEPTH(MAX_GRID)) u_mid_c (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (c_s1),
		.wdata (x_s1),
		.re    (accept),
		.raddr (c0),
		.rdata (mid_c_rd)
	);

	hdsc_ram #(.WIDTH(CELL_W), .DEPTH(MAX_GRID)) u_mid_e (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (c_s1),
		.wdata (x_s1),
		.re    (accept),
		.raddr (c0p1[AW-1:0]),
		.rdata (mid_e_rd)
	);

	hdsc_ram #(.WIDTH(CELL_W), .DEPTH(MAX_GRID)) u_upper (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (c_s1),
		.wdata (centre),
		.re    (accept),
		.raddr (c0),
		.rdata (up_rd)
	);

	// Neighbors after forwarding
	assign centre = hit_c_s1 ? fwd_mid_s1 : mid_c_rd;
	assign north  = hit_c_s1 ? fwd_up_s1 : up_rd;
	assign east   = ez_s1 ? '0 : (hit_e_s1 ? fwd_mid_s1 : mid_e_rd);

	// West cell: previous centre
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q <= centre;
		end
	end

	hdsc_stencil #(.FRAC_BITS(FRAC_BITS)) u_stencil (
		.north  (north),
		.south  (x_s1),
		.east   (east),
		.west   (win_q),
		.centre (centre),
		.coeff  (coeff_q),
		.result (interior)
	);

	// Finished item for the result register
	always_comb begin
		res.row_a = POS_W'(r_s1 - AW'(1));
		res.row_b = POS_W'(r_s1);
		res.col   = POS_W'(c_s1);
		res.val_a = border_s1 ? centre : interior;
		res.val_b = x_s1;
		res.has_a = has_a_s1;
		res.has_b = has_b_s1;
	end

	hdsc_result u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (s1_adv),
		.res     (res),
		.free    (s2_free),
		.results (results)
	);

	// An accepted beat is in stage 1 on the next cycle
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted cell missing from stage 1");

	// A non-final result beat is always followed by another
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.last_of_run |=> results.valid)
		else $error("result run ended early");

	// Last-row cell always also finishes the cell above it
	a_two_res: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && has_b_s1 |-> has_a_s1)
		else $error("last-row item without upper result");

	// No east neighbor only on a border column
	a_east_border: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ez_s1 |-> border_s1)
		else $error("east neighbor dropped on interior cell");
endmodule

`default_nettype wire

FILE: design/hdsc_ram.sv
// ----------------------------------------------------------------------------
// hdsc_ram: generic single-port-write, single-port-read RAM
// Registered read with enable; a read of the address being written returns
// the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module hdsc_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

FILE: design/hdsc_stencil.sv
// ----------------------------------------------------------------------------
// hdsc_stencil: five-point update of one interior cell
// c + floor(phi * (n + s + e + w - 4c) / 2^16), clamped to 0 .. 127.0.
// ----------------------------------------------------------------------------
`default_nettype none

module hdsc_stencil #(
	parameter int FRAC_BITS = hdsc_pkg::DEF_FRAC_BITS
) (
	input  wire logic [hdsc_pkg::CELL_W-1:0]  north,
	input  wire logic [hdsc_pkg::CELL_W-1:0]  south,
	input  wire logic [hdsc_pkg::CELL_W-1:0]  east,
	input  wire logic [hdsc_pkg::CELL_W-1:0]  west,
	input  wire logic [hdsc_pkg::CELL_W-1:0]  centre,
	input  wire logic [hdsc_pkg::COEFF_W-1:0] coeff,
	output logic      [hdsc_pkg::CELL_W-1:0]  result
);
	import hdsc_pkg::*;

	// Laplacian, product and shifted delta widths
	localparam int SUM_W   = CELL_W + 2;
	localparam int LAP_W   = SUM_W + 1;
	localparam int PROD_W  = COEFF_W + 1 + LAP_W;
	localparam int DELTA_W = PROD_W - 16;
	// Sum width: wide enough for c + delta and for the clamp ceiling
	localparam int TOP_W   = 8 + FRAC_BITS;
	localparam int SW      = (TOP_W + 1 > DELTA_W + 1) ? TOP_W + 1 : DELTA_W + 1;
	localparam logic signed [SW-1:0] TOP = SW'(CLAMP_INT) <<< FRAC_BITS;

	logic        [SUM_W-1:0]   nsew;
	logic signed [LAP_W-1:0]   lap;
	logic signed [PROD_W-1:0]  prod;
	logic signed [DELTA_W-1:0] delta;
	logic signed [SW-1:0]      v;

	// Laplacian in Q7.8 units
	assign nsew = SUM_W'(north) + SUM_W'(south) + SUM_W'(east) + SUM_W'(west);
	assign lap  = $signed({1'b0, nsew}) - $signed({1'b0, centre, 2'b00});

	// Q0.16 times laplacian, floor to cell units
	assign prod  = $signed({1'b0, coeff}) * lap;
	assign delta = prod[PROD_W-1:16];

	// Saturate to 0 .. 127.0
	assign v = $signed(SW'(centre)) + SW'(delta);

	always_comb begin
		if (v < 0) begin
			result = '0;
		end else if (v > TOP) begin
			result = TOP[CELL_W-1:0];
		end else begin
			result = v[CELL_W-1:0];
		end
	end
endmodule

`default_nettype wire

FILE: design/hdsc_result.sv
// ----------------------------------------------------------------------------
// hdsc_result: result register and beat sequencer
// Holds one finished item and plays out its result beats: none, one or two.
// ----------------------------------------------------------------------------
`default_nettype none

module hdsc_result (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire hdsc_pkg::res_load_t res,
	output logic                     free,
	hdsc_out_if.source               results
);
	import hdsc_pkg::*;

	logic              pend_a_s2;
	logic              pend_b_s2;
	logic [POS_W-1:0]  row_a_s2;
	logic [POS_W-1:0]  row_b_s2;
	logic [POS_W-1:0]  col_s2;
	logic [CELL_W-1:0] val_a_s2;
	logic [CELL_W-1:0] val_b_s2;
	logic              last;
	logic              beat;

	// Current beat: the cell above first, then the last-row cell
	assign last = pend_a_s2 ? !pend_b_s2 : 1'b1;
	assign beat = results.valid && results.ready;
	assign free = !(pend_a_s2 || pend_b_s2) || (beat && last);

	assign results.valid       = pend_a_s2 || pend_b_s2;
	assign results.out_row     = pend_a_s2 ? row_a_s2 : row_b_s2;
	assign results.out_col     = col_s2;
	assign results.cell_out    = pend_a_s2 ? val_a_s2 : val_b_s2;
	assign results.last_of_run = last;

	// Pending flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_a_s2 <= 1'b0;
			pend_b_s2 <= 1'b0;
		end else if (load) begin
			pend_a_s2 <= res.has_a;
			pend_b_s2 <= res.has_b;
		end else if (beat) begin
			if (pend_a_s2) begin
				pend_a_s2 <= 1'b0;
			end else begin
				pend_b_s2 <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			row_a_s2 <= res.row_a;
			row_b_s2 <= res.row_b;
			col_s2   <= res.col;
			val_a_s2 <= res.val_a;
			val_b_s2 <= res.val_b;
		end
	end
endmodule

`default_nettype wire

FILE: dv/heat_diffusion_stencil_clamped_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_clamped_unit_tb: self-checking bench of the heat stencil
// Streams raster grids through the unit and predicts every updated cell with
// row and column from a model of the line stores kept here. Checks each
// result beat, changes grid size and coefficient between phases, and mixes
// source gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------

module heat_diffusion_stencil_clamped_unit_tb;
	import hdsc_pkg::*;

	localparam int TOP_CELL      = CLAMP_INT << DEF_FRAC_BITS;
	localparam int RANDOM_CELLS  = 420;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 4000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	typedef struct packed {
		logic [CELL_W-1:0] temp;
		logic              frame_start;
	} cell_beat_t;

	typedef struct packed {
		logic [POS_W-1:0]  row_idx;
		logic [POS_W-1:0]  col_idx;
		logic [CELL_W-1:0] temp;
		logic              last_flag;
	} cell_result_t;

	// Directed 3x3 grids: hot center clamps high, near-equal cells show
	// floor rounding of a negative update, hot center with cold ring clamps low
	localparam logic [CELL_W-1:0] HOT_GRID [9] = '{
		15'd0,     15'd32767, 15'd0,
		15'd32767, 15'd32512, 15'd32767,
		15'd0,     15'd32767, 15'd0};
	localparam logic [CELL_W-1:0] FLOOR_GRID [9] = '{
		15'd1,   15'd255, 15'd2,
		15'd255, 15'd256, 15'd255,
		15'd3,   15'd255, 15'd4};
	localparam logic [CELL_W-1:0] COLD_GRID [9] = '{
		15'd0, 15'd0,     15'd0,
		15'd0, 15'd32767, 15'd0,
		15'd0, 15'd0,     15'd0};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DAT_W-1:0] wr_data;

	hdsc_in_if  cells_if ();
	hdsc_out_if res_if ();

	heat_diffusion_stencil_clamped_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cells    (cells_if),
		.results  (res_if)
	);

	always #2 clk = ~clk;

	// Stimulus and expectation stores
	cell_beat_t   pending_cells [$];
	cell_result_t expected_cells [$];
	int           mismatch_count = 0;
	int           random_cells_sent = 0;
	int           tx_idle_pct = 0;
	int           rx_stall_pct = 0;
	int           hold_token = 0;

	// Predictor state: registers, line stores, window, position
	logic [GRID_W-1:0]  grid_cfg = GRID_RESET;
	logic [COEFF_W-1:0] coeff_cfg = COEFF_RESET;
	logic [CELL_W-1:0]  line_upper [DEF_MAX_GRID];
	logic [CELL_W-1:0]  line_middle [DEF_MAX_GRID];
	logic [CELL_W-1:0]  window [3];
	int                 row_cnt = 0;
	int                 col_cnt = 0;

	initial begin
		for (int k = 0; k < DEF_MAX_GRID; k++) begin
			line_upper[k]  = '0;
			line_middle[k] = '0;
		end
		for (int k = 0; k < 3; k++) window[k] = '0;
	end

	function automatic int grid_in_use();
		int g;
		g = int'(grid_cfg);
		if (g < GRID_MIN) g = GRID_MIN;
		if (g > DEF_MAX_GRID) g = DEF_MAX_GRID;
		return g;
	endfunction

	// c + phi*(n+s+e+w-4c), floor of the Q.24 product, clamped to 0..127.0
	function automatic logic [CELL_W-1:0] relax_cell(input logic [CELL_W-1:0] nv,
		input logic [CELL_W-1:0] sv, input logic [CELL_W-1:0] ev,
		input logic [CELL_W-1:0] wv, input logic [CELL_W-1:0] cv);
		longint lap;
		longint prod;
		longint v;
		lap  = longint'(nv) + longint'(sv) + longint'(ev) + longint'(wv) - 4 * longint'(cv);
		prod = longint'(coeff_cfg) * lap;
		v    = longint'(cv) + (prod >>> 16);
		if (v < 0) v = 0;
		if (v > TOP_CELL) v = TOP_CELL;
		return v[CELL_W-1:0];
	endfunction

	// Advance the sweep by one accepted cell and queue the cells it finishes
	task automatic predict_sweep(input logic [CELL_W-1:0] x, input logic fs);
		int g;
		int r;
		int c;
		logic [CELL_W-1:0] centre;
		logic [CELL_W-1:0] north;
		logic [CELL_W-1:0] east;
		cell_result_t res;
		g = grid_in_use();
		if (fs) begin
			row_cnt = 0;
			col_cnt = 0;
		end
		if (col_cnt >= g) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (row_cnt >= g) row_cnt = 0;
		r = row_cnt;
		c = col_cnt;

		centre = line_middle[c];
		north  = line_upper[c];
		east   = (c + 1 < g) ? line_middle[c + 1] : '0;
		window[0] = window[1];
		window[1] = centre;
		window[2] = east;

		// cell above is finished; border cells pass through
		if (r >= 1) begin
			res.row_idx = POS_W'(r - 1);
			res.col_idx = POS_W'(c);
			if (r == 1 || c == 0 || c == g - 1)
				res.temp = centre;
			else
				res.temp = relax_cell(north, x, window[2], window[0], centre);
			res.last_flag = (r != g - 1);
			expected_cells.push_back(res);
		end
		// last row goes out right away
		if (r == g - 1) begin
			res.row_idx   = POS_W'(r);
			res.col_idx   = POS_W'(c);
			res.temp      = x;
			res.last_flag = 1'b1;
			expected_cells.push_back(res);
		end

		line_upper[c]  = centre;
		line_middle[c] = x;
		col_cnt = c + 1;
		if (col_cnt >= g) begin
			col_cnt = 0;
			row_cnt = r + 1;
			if (row_cnt >= g) row_cnt = 0;
		end
	endtask

	// Source driver: holds a beat until accepted, idles at random when free
	always @(posedge clk) begin
		cell_beat_t nxt;
		if (cells_if.valid && cells_if.ready)
			predict_sweep(cells_if.cell_in, cells_if.frame_start);
		if (!cells_if.valid || cells_if.ready) begin
			if (pending_cells.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = pending_cells.pop_front();
				cells_if.valid       <= 1'b1;
				cells_if.cell_in     <= nxt.temp;
				cells_if.frame_start <= nxt.frame_start;
			end else begin
				cells_if.valid <= 1'b0;
			end
		end
	end

	// Result monitor and sink ready; a new hold token starts a long hold-off
	always @(posedge clk) begin
		cell_result_t want;
		static int hold_seen = 0;
		static int hold_left = 0;
		if (res_if.valid && res_if.ready) begin
			if (expected_cells.size() == 0) begin
				$error("unexpected result beat: row %0d col %0d cell %0d",
					res_if.out_row, res_if.out_col, res_if.cell_out);
				mismatch_count++;
			end else begin
				want = expected_cells.pop_front();
				if (res_if.out_row !== want.row_idx) begin
					$error("out_row: expected %0d, got %0d", want.row_idx, res_if.out_row);
					mismatch_count++;
				end
				if (res_if.out_col !== want.col_idx) begin
					$error("out_col: expected %0d, got %0d", want.col_idx, res_if.out_col);
					mismatch_count++;
				end
				if (res_if.cell_out !== want.temp) begin
					$error("cell_out: expected %0d, got %0d", want.temp, res_if.cell_out);
					mismatch_count++;
				end
				if (res_if.last_of_run !== want.last_flag) begin
					$error("last_of_run: expected %0d, got %0d", want.last_flag,
						res_if.last_of_run);
					mismatch_count++;
				end
			end
		end
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		static int quiet_cycles = 0;
		if ((cells_if.valid && cells_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= dat;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_GRID_SIZE)
			grid_cfg = dat[GRID_W-1:0];
		else
			coeff_cfg = dat[COEFF_W-1:0];
	endtask

	// Grid size write with random bits above the register width
	task automatic write_grid(input int raw);
		logic [CFG_DAT_W-1:0] dat;
		dat = CFG_DAT_W'($urandom);
		dat[GRID_W-1:0] = GRID_W'(raw);
		write_reg(REG_GRID_SIZE, dat);
	endtask

	task automatic write_random_coeff();
		case ($urandom_range(3))
			0: write_reg(REG_DIFF_COEFF, '0);
			1: write_reg(REG_DIFF_COEFF, '1);
			default: write_reg(REG_DIFF_COEFF, CFG_DAT_W'($urandom));
		endcase
	endtask

	task automatic set_idling(input idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				tx_idle_pct  = 0;
				rx_stall_pct = 0;
			end
			IDLE_SENDER: begin
				tx_idle_pct  = 78;
				rx_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				tx_idle_pct  = 0;
				rx_stall_pct = 78;
			end
			default: begin
				tx_idle_pct  = 26;
				rx_stall_pct = 26;
			end
		endcase
	endtask

	// Sender stops until every expected cell is back and the pipe is empty
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_cells.size() != 0 || cells_if.valid || expected_cells.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Every queued cell counts toward the run length
	task automatic push_cell(input logic [CELL_W-1:0] temp, input logic fs);
		cell_beat_t b;
		b.temp        = temp;
		b.frame_start = fs;
		pending_cells.push_back(b);
		random_cells_sent++;
	endtask

	task automatic queue_grid3(input logic [CELL_W-1:0] vals [9]);
		for (int k = 0; k < 9; k++) push_cell(vals[k], k == 0);
	endtask

	// Smooth field around a base, with extremes and full-width values mixed in
	function automatic logic [CELL_W-1:0] rand_cell(input int base);
		int v;
		case ($urandom_range(9))
			0: v = $urandom_range(0, (1 << CELL_W) - 1);
			1: begin
				case ($urandom_range(2))
					0: v = 0;
					1: v = TOP_CELL;
					default: v = (1 << CELL_W) - 1;
				endcase
			end
			default: begin
				v = base + int'($urandom_range(0, 1023)) - 512;
				if (v < 0) v = 0;
				if (v > TOP_CELL) v = TOP_CELL;
			end
		endcase
		return CELL_W'(v);
	endfunction

	// Whole grids in raster order; rare frame restarts mid-grid as noise
	task automatic queue_grids(input int g, input int n_grids);
		int base;
		int idx;
		logic fs;
		for (int k = 0; k < n_grids; k++) begin
			base = $urandom_range(0, TOP_CELL);
			idx  = 0;
			while (idx < g * g) begin
				if (idx == 0) begin
					fs = (k == 0) || ($urandom_range(7) != 0);
				end else begin
					fs = ($urandom_range(63) == 0);
					if (fs) idx = 0;
				end
				push_cell(rand_cell(base), fs);
				idx++;
			end
		end
	endtask

	initial begin
		int phase_no;
		int g;
		int base;
		cells_if.valid       = 1'b0;
		cells_if.cell_in     = '0;
		cells_if.frame_start = 1'b0;
		res_if.ready         = 1'b0;
		wr_en                = 1'b0;
		wr_index             = '0;
		wr_data              = '0;
		arst_n               = 1'b0;
		phase_no             = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: size below minimum, reset coefficient, clamp high, floor rounding
		set_idling(IDLE_NONE);
		write_grid(0);
		queue_grid3(HOT_GRID);
		queue_grid3(FLOOR_GRID);
		wait_drained();

		// Directed: full coefficient, restart in mid row, clamp low
		write_grid(2);
		write_reg(REG_DIFF_COEFF, '1);
		for (int k = 0; k < 4; k++) push_cell(CELL_W'(k * 1000 + 7), k == 0);
		queue_grid3(COLD_GRID);
		wait_drained();

		// Small grid, zero coefficient
		set_idling(IDLE_SENDER);
		write_grid(3);
		write_reg(REG_DIFF_COEFF, '0);
		queue_grids(3, 4);
		wait_drained();

		// Long sink hold-off with the source streaming flat out
		set_idling(IDLE_NONE);
		write_grid(5);
		write_random_coeff();
		hold_token++;
		queue_grids(5, 4);
		wait_drained();

		// Partial grid, then a smaller size wraps the column count to the next row
		set_idling(IDLE_RECEIVER);
		write_grid(12);
		write_random_coeff();
		base = $urandom_range(0, TOP_CELL);
		for (int k = 0; k < 32; k++) push_cell(rand_cell(base), k == 0);
		wait_drained();
		write_grid(6);
		for (int k = 0; k < 18; k++) push_cell(rand_cell(base), 1'b0);
		queue_grids(6, 1);
		wait_drained();

		// Size at or above the maximum: a stretch of the first row yields nothing
		set_idling(IDLE_BOTH);
		write_grid($urandom_range(DEF_MAX_GRID, (1 << GRID_W) - 1));
		write_random_coeff();
		base = $urandom_range(0, TOP_CELL);
		for (int k = 0; k < 48; k++) push_cell(rand_cell(base), k == 0);
		wait_drained();

		// Random phases over sizes, coefficients and idling
		while (random_cells_sent < RANDOM_CELLS) begin
			set_idling(idle_mode_e'(phase_no % 4));
			phase_no++;
			if ($urandom_range(5) == 0)
				g = $urandom_range(10, 12);
			else
				g = $urandom_range(3, 9);
			write_grid((g == GRID_MIN) ? $urandom_range(0, GRID_MIN) : g);
			write_random_coeff();
			queue_grids(g, (g > 9) ? 1 : $urandom_range(1, 3));
			wait_drained();
		end

		if (mismatch_count == 0 && expected_cells.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
